### hw/rtl/sfr_pkg.sv
// package for the sliding frame receiver: frame geometry, checksum constants,
// register map and shared byte types; no dependencies
package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 13;
    localparam int SUM_FIRST   = 4;
    localparam int NUM_FIELDS  = 11;
    localparam int FILL_W      = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [BYTE_W-1:0] SUM_TARGET = 8'hFF;

    // register indexes
    localparam logic REG_START_BYTE = 1'b0;

    typedef logic [BYTE_W-1:0] t_byte;
    // the twelve bytes held ahead of the newest one, index 0 the oldest
    typedef t_byte t_hist [FRAME_BYTES-1];

endpackage

### hw/rtl/sfr_frame_chk.sv
// frame check: start byte compare and additive checksum over frame bytes 4 to 12
// depends on sfr_pkg
module sfr_frame_chk (
    input  sfr_pkg::t_byte i_start_byte,
    input  sfr_pkg::t_hist i_hist,
    input  sfr_pkg::t_byte i_newest,
    output logic           o_frame_ok
);
    import sfr_pkg::*;

    t_byte w_sum;

    always_comb begin
        w_sum = i_newest;
        for (int k = SUM_FIRST; k < FRAME_BYTES - 1; k++) begin
            w_sum = t_byte'(w_sum + i_hist[k]);
        end
    end

    assign o_frame_ok = (i_hist[0] == i_start_byte) && (w_sum == SUM_TARGET);

endmodule

### hw/rtl/sliding_frame_receiver_unit.sv
// sliding frame receiver: an accepted byte passes from the input register through the
// frame check to the result register; throughput one byte per cycle when not stalled,
// set by the single check stage between the input register and the result register
// a matching frame waits in the result register; the next byte is stalled only if
// it too completes a frame while that result has not been taken
// synchronous active-low reset clears the fill count, valid flags and start byte
module sliding_frame_receiver_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sfr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sfr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sfr_pkg::BYTE_W-1:0]       o_frame_address,
    output logic [sfr_pkg::BYTE_W-1:0]       o_frame_data_id,
    output logic [sfr_pkg::BYTE_W-1:0]       o_frame_length,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_0,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_1,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_2,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_3,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_4,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_5,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_6,
    output logic [sfr_pkg::BYTE_W-1:0]       o_payload_7
);
    import sfr_pkg::*;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);

    t_byte             r_start_byte;
    logic              r_in_valid;
    t_byte             r_in_byte;
    t_hist             r_hist;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_out_valid;
    t_byte             r_out [NUM_FIELDS];

    logic w_cfg_wr;
    logic w_in_acc;
    logic w_frame_ok;
    logic w_complete;
    logic w_out_free;
    logic w_adv;
    logic w_load_out;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_START_BYTE) ?
                      APB_DATA_W'(r_start_byte) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
        end else if (w_cfg_wr && paddr[2] == REG_START_BYTE) begin
            r_start_byte <= pwdata[BYTE_W-1:0];
        end
    end

    sfr_frame_chk u_chk (
        .i_start_byte (r_start_byte),
        .i_hist       (r_hist),
        .i_newest     (r_in_byte),
        .o_frame_ok   (w_frame_ok)
    );

    assign w_complete = (r_fill == FILL_LAST) && w_frame_ok;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && (!w_complete || w_out_free);
    assign w_load_out = w_adv && w_complete;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_fill = r_fill;
        if (w_adv) begin
            if (w_complete) begin
                n_fill = '0;
            end else if (r_fill != FILL_LAST) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // history shift line, newest byte enters at the top
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < FRAME_BYTES - 2; k++) begin
                r_hist[k] <= r_hist[k+1];
            end
            r_hist[FRAME_BYTES-2] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_out[k] <= r_hist[k+1];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_address = r_out[0];
    assign o_frame_data_id = r_out[1];
    assign o_frame_length  = r_out[2];
    assign o_payload_0     = r_out[3];
    assign o_payload_1     = r_out[4];
    assign o_payload_2     = r_out[5];
    assign o_payload_3     = r_out[6];
    assign o_payload_4     = r_out[7];
    assign o_payload_5     = r_out[8];
    assign o_payload_6     = r_out[9];
    assign o_payload_7     = r_out[10];

`ifndef ASSERT_OFF
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_LAST)
        else $error("window fill out of range");

    a_empty_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_fill == '0) && r_out_valid)
        else $error("window not emptied after frame");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_complete && r_out_valid && i_out_stall)
        else $error("request stalled without a blocked frame");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out[0]))
        else $error("pending frame lost");
`endif

endmodule
